// File: src/twcc_pkg.sv
// ----------------------------------------------------------------------------
// twcc_pkg
// Types, codes and helpers shared by the text window cursor controller.
// ----------------------------------------------------------------------------
package twcc_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 32;
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 13;
    localparam int EDGE_W   = 12;
    localparam int ZOOM_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // signed working width for cursor sums; covers 8191 plus two cells of 32 * 15
    localparam int CALC_W = 16;

    localparam int GLYPH_WIDTH_DEF  = 8;
    localparam int GLYPH_HEIGHT_DEF = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_HOME  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 3'd4;

    localparam logic [EDGE_W-1:0] LEFT_RST   = 12'd0;
    localparam logic [EDGE_W-1:0] TOP_RST    = 12'd0;
    localparam logic [EDGE_W-1:0] RIGHT_RST  = 12'd639;
    localparam logic [EDGE_W-1:0] BOTTOM_RST = 12'd479;
    localparam logic [ZOOM_W-1:0] ZOOM_RST   = 4'd1;

    localparam logic signed [CALC_W-1:0] ONE_S       = 16'sd1;
    localparam logic signed [CALC_W-1:0] ZERO_S      = 16'sd0;
    localparam logic signed [CALC_W-1:0] COORD_MAX_S = 16'sd8191;

    typedef struct packed {
        logic [EDGE_W-1:0] left;
        logic [EDGE_W-1:0] top;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] bottom;
        logic [ZOOM_W-1:0] zoom;
    } t_cfg;

    // one classified item: optional draw/erase, optional clear after it
    typedef struct packed {
        logic               has_main;
        logic               is_erase;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAR_W-1:0]  code;
        logic [COLOR_W-1:0] color;
        logic               has_clear;
    } t_entry;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [CHAR_W-1:0]  glyph_code;
        logic [COLOR_W-1:0] glyph_color;
        logic               last;
    } t_result;

    function automatic logic [COORD_W-1:0] sat13(input logic signed [CALC_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v < ZERO_S) begin
            r = '0;
        end else if (v > COORD_MAX_S) begin
            r = '1;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/twcc_in_if.sv
// ----------------------------------------------------------------------------
// twcc_in_if
// Action channel: valid/ready with action, character and colour.
// ----------------------------------------------------------------------------
interface twcc_in_if;
    import twcc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  char_color;

    modport source (output valid, action, char_code, char_color, input ready);
    modport sink   (input valid, action, char_code, char_color, output ready);
endinterface

// File: src/twcc_out_if.sv
// ----------------------------------------------------------------------------
// twcc_out_if
// Drawing command channel: valid/ready with one command per beat.
// ----------------------------------------------------------------------------
interface twcc_out_if;
    import twcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [CHAR_W-1:0]  glyph_code;
    logic [COLOR_W-1:0] glyph_color;
    logic               last;

    modport source (output valid, command, x_start, y_start, x_end, y_end,
                    glyph_code, glyph_color, last, input ready);
    modport sink   (input valid, command, x_start, y_start, x_end, y_end,
                    glyph_code, glyph_color, last, output ready);
endinterface

// File: src/twcc_front.sv
// ----------------------------------------------------------------------------
// twcc_front
// Accepts actions, updates the cursor and classifies the commands to emit.
// ----------------------------------------------------------------------------
module twcc_front #(
    parameter int GLYPH_WIDTH  = twcc_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = twcc_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twcc_pkg::t_cfg   i_cfg,
    twcc_in_if.sink          i_item,
    input  logic             i_queue_full,
    output logic             o_push,
    output twcc_pkg::t_entry o_entry
);
    import twcc_pkg::*;

    logic [COORD_W-1:0] r_cursor_x, r_cursor_y;
    logic [COORD_W-1:0] n_cursor_x, n_cursor_y;
    logic [COORD_W-1:0] home_x, home_y;
    logic signed [CALC_W-1:0] cw, chh, lm, tm, max_x, max_y;
    logic accept;
    t_entry entry;

    assign cw     = CALC_W'(GLYPH_WIDTH * int'(i_cfg.zoom));
    assign chh    = CALC_W'(GLYPH_HEIGHT * int'(i_cfg.zoom));
    assign lm     = CALC_W'(i_cfg.left) + ONE_S;
    assign tm     = CALC_W'(i_cfg.top) + ONE_S;
    assign max_x  = CALC_W'(i_cfg.right) - cw;
    assign max_y  = CALC_W'(i_cfg.bottom) - chh;
    assign home_x = lm[COORD_W-1:0];
    assign home_y = tm[COORD_W-1:0];

    assign i_item.ready = !i_queue_full;
    assign accept       = i_item.valid && !i_queue_full;
    assign o_entry      = entry;
    assign o_push       = accept && (entry.has_main || entry.has_clear);

    always_comb begin
        logic signed [CALC_W-1:0] x;
        logic signed [CALC_W-1:0] y;
        x          = CALC_W'(r_cursor_x);
        y          = CALC_W'(r_cursor_y);
        entry      = '0;
        entry.x    = r_cursor_x;
        entry.y    = r_cursor_y;
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        case (i_item.action)
            ACT_HOME: begin
                n_cursor_x = home_x;
                n_cursor_y = home_y;
            end
            ACT_CLEAR: begin
                entry.has_clear = 1'b1;
                n_cursor_x      = home_x;
                n_cursor_y      = home_y;
            end
            ACT_PUT: begin
                case (i_item.char_code)
                    CH_RETURN: begin
                        x = lm;
                    end
                    CH_LINEFEED: begin
                        x = lm;
                        y = y + chh;
                    end
                    CH_BACKSPACE: begin
                        if (x > lm) begin
                            x = x - cw;
                            if (x < ZERO_S) begin
                                x = ZERO_S;
                            end
                            entry.has_main = 1'b1;
                            entry.is_erase = 1'b1;
                            entry.x        = x[COORD_W-1:0];
                        end
                    end
                    default: begin
                        entry.has_main = 1'b1;
                        entry.code     = i_item.char_code;
                        entry.color    = i_item.char_color;
                        x              = x + cw;
                    end
                endcase
                if (x > max_x) begin
                    x = lm;
                    y = y + chh;
                end
                if (y > max_y) begin
                    y               = tm;
                    entry.has_clear = 1'b1;
                end
                n_cursor_x = x[COORD_W-1:0];
                n_cursor_y = y[COORD_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= COORD_W'(LEFT_RST) + COORD_W'(1);
            r_cursor_y <= COORD_W'(TOP_RST) + COORD_W'(1);
        end else if (accept) begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end

endmodule

// File: src/twcc_queue.sv
// ----------------------------------------------------------------------------
// twcc_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module twcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  twcc_pkg::t_entry i_push_data,
    input  logic             i_pop,
    output twcc_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);
    import twcc_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// File: src/twcc_back.sv
// ----------------------------------------------------------------------------
// twcc_back
// Expands queued items into drawing command beats through an output register.
// ----------------------------------------------------------------------------
module twcc_back #(
    parameter int GLYPH_WIDTH  = twcc_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = twcc_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twcc_pkg::t_cfg   i_cfg,
    input  twcc_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    twcc_out_if.source       o_result
);
    import twcc_pkg::*;

    logic    r_valid;
    logic    r_second;
    t_result r_res;
    t_result res;
    logic    load;
    logic    want_main;
    logic signed [CALC_W-1:0] cw, chh, erase_xe, erase_ye;
    logic signed [CALC_W-1:0] clr_xs, clr_ys, clr_xe, clr_ye;

    assign cw       = CALC_W'(GLYPH_WIDTH * int'(i_cfg.zoom));
    assign chh      = CALC_W'(GLYPH_HEIGHT * int'(i_cfg.zoom));
    assign erase_xe = CALC_W'(i_head.x) + cw - ONE_S;
    assign erase_ye = CALC_W'(i_head.y) + chh - ONE_S;
    assign clr_xs   = CALC_W'(i_cfg.left) + ONE_S;
    assign clr_ys   = CALC_W'(i_cfg.top) + ONE_S;
    assign clr_xe   = CALC_W'(i_cfg.right) - ONE_S;
    assign clr_ye   = CALC_W'(i_cfg.bottom) - ONE_S;

    assign want_main = i_head.has_main && !r_second;
    assign load      = !i_empty && (!r_valid || o_result.ready);
    assign o_pop     = load && !(want_main && i_head.has_clear);

    always_comb begin
        res = '0;
        if (want_main) begin
            res.x_start = i_head.x;
            res.y_start = i_head.y;
            res.last    = !i_head.has_clear;
            if (i_head.is_erase) begin
                res.command = CMD_ERASE;
                res.x_end   = sat13(erase_xe);
                res.y_end   = sat13(erase_ye);
            end else begin
                res.command     = CMD_DRAW;
                res.glyph_code  = i_head.code;
                res.glyph_color = i_head.color;
            end
        end else begin
            res.command = CMD_CLEAR;
            res.x_start = sat13(clr_xs);
            res.y_start = sat13(clr_ys);
            res.x_end   = sat13(clr_xe);
            res.y_end   = sat13(clr_ye);
            res.last    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= want_main && i_head.has_clear;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= res;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.command     = r_res.command;
    assign o_result.x_start     = r_res.x_start;
    assign o_result.y_start     = r_res.y_start;
    assign o_result.x_end       = r_res.x_end;
    assign o_result.y_end       = r_res.y_end;
    assign o_result.glyph_code  = r_res.glyph_code;
    assign o_result.glyph_color = r_res.glyph_color;
    assign o_result.last        = r_res.last;

endmodule

// File: src/text_window_cursor_control_unit.sv
// ----------------------------------------------------------------------------
// text_window_cursor_control_unit
// Text cursor kept inside a window; actions in, drawing commands out.
// ----------------------------------------------------------------------------
// One action is accepted per clock while the four-entry item queue has room.
// Each action gives zero, one or two command beats (draw or erase, then
// possibly a clear of the window interior); the last beat of an action has
// last set. The output register issues one beat per clock while the sink is
// ready; an accepted action's first beat is loaded from the queue head when the
// register frees. Cells are GLYPH_WIDTH by GLYPH_HEIGHT times the zoom register.
// Registers: 0 left, 1 top, 2 right, 3 bottom, 4 zoom; write them only when
// no beats are outstanding. Register writes do not move the cursor.
module text_window_cursor_control_unit #(
    parameter int GLYPH_WIDTH  = twcc_pkg::GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = twcc_pkg::GLYPH_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [twcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [twcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    twcc_in_if.sink                             i_item,
    twcc_out_if.source                          o_result
);
    import twcc_pkg::*;

    t_cfg   r_cfg;
    t_entry push_data;
    t_entry head;
    logic   push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= LEFT_RST;
            r_cfg.top    <= TOP_RST;
            r_cfg.right  <= RIGHT_RST;
            r_cfg.bottom <= BOTTOM_RST;
            r_cfg.zoom   <= ZOOM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[EDGE_W-1:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[EDGE_W-1:0];
                CFG_RIGHT:  r_cfg.right  <= i_cfg_data[EDGE_W-1:0];
                CFG_BOTTOM: r_cfg.bottom <= i_cfg_data[EDGE_W-1:0];
                CFG_ZOOM:   r_cfg.zoom   <= i_cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    twcc_front #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (i_item),
        .i_queue_full (full),
        .o_push       (push),
        .o_entry      (push_data)
    );

    twcc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (full),
        .o_empty     (empty)
    );

    twcc_back #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
